@@ sv/swmf_pkg.sv @@
`timescale 1ns / 1ps
package swmf_pkg;
    localparam int WindowMax = 16;
    localparam int AddrW     = $clog2(WindowMax);
    localparam int CntW      = $clog2(WindowMax + 1);
    localparam int SampleW   = 16;
    localparam int CfgW      = 5;
    localparam logic [CfgW-1:0] SizeReset = CfgW'(5);

    typedef logic signed [SampleW-1:0] t_sample;
    typedef logic [AddrW-1:0]          t_addr;
    typedef logic [CntW-1:0]           t_cnt;

    // Clamp the configured size to 1 .. WindowMax
    function automatic t_cnt eff_size(input logic [CfgW-1:0] sz);
        t_cnt n;
        n = t_cnt'(WindowMax);
        if (sz == '0) begin
            n = t_cnt'(1);
        end else if (32'(sz) < WindowMax) begin
            n = t_cnt'(sz);
        end
        return n;
    endfunction
endpackage

@@ sv/sliding_window_median_filter.sv @@
`timescale 1ns / 1ps
// Each accepted sample starts a pass that reads the window store, one entry per cycle,
// into the insertion sorter, then loads the median into the output register.
// No new sample is taken until the previous median has entered the output register;
// a median waiting in the output register stalls the block only once the next median
// is ready to take its place. After reset a clearing pass zeroes all 16 entries of
// the window store; no sample is taken until it ends. Size resets to 5.
module sliding_window_median_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_window_size,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic signed [15:0] i_sample,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_median
);
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_LAST  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state                 r_state;
    logic [swmf_pkg::CfgW-1:0] r_size;
    swmf_pkg::t_addr        r_wp;
    swmf_pkg::t_cnt         r_cnt;
    swmf_pkg::t_cnt         n_eff;
    logic                   r_ovalid;
    swmf_pkg::t_sample      r_med;
    logic                   we;
    swmf_pkg::t_addr        waddr;
    swmf_pkg::t_sample      wdata;
    swmf_pkg::t_sample      rdata;
    swmf_pkg::t_sample      median;
    logic                   push;
    swmf_pkg::t_addr        wsel;
    logic                   emit;

    assign n_eff = swmf_pkg::eff_size(r_size);
    assign wsel  = (swmf_pkg::t_cnt'(r_wp) >= n_eff) ? '0 : r_wp;

    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_median = r_med;

    // Load the output register once it is empty or being taken
    assign emit = (r_state == S_OUT) && (!r_ovalid || i_ready);

    // Memory write: clearing pass or new sample
    always_comb begin
        we    = 1'b0;
        waddr = wsel;
        wdata = i_sample;
        if (r_state == S_CLEAR) begin
            we    = 1'b1;
            waddr = swmf_pkg::t_addr'(r_cnt);
            wdata = '0;
        end else if (i_valid && o_ready) begin
            we = 1'b1;
        end
    end

    swmf_ram #(.Depth(swmf_pkg::WindowMax), .Width(swmf_pkg::SampleW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (swmf_pkg::t_addr'(r_cnt)),
        .o_rdata (rdata)
    );

    assign push = (r_state == S_READ && r_cnt != '0) || r_state == S_LAST;

    swmf_sorter u_sort (
        .i_clk    (i_clk),
        .i_clear  (r_state == S_IDLE),
        .i_push   (push),
        .i_value  (rdata),
        .i_size   (n_eff),
        .o_median (median)
    );

    // Sequencer: clear, wait, stream window through sorter, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_wp     <= '0;
            r_size   <= swmf_pkg::SizeReset;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_window_size;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_cnt == swmf_pkg::t_cnt'(swmf_pkg::WindowMax - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_wp    <= (swmf_pkg::t_cnt'(wsel) + 1'b1 >= n_eff)
                                   ? '0 : wsel + 1'b1;
                        r_cnt   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt + 1'b1 == n_eff) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold the sorted row until the output register is free
                    if (emit) begin
                        r_med   <= median;
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ sv/swmf_ram.sv @@
`timescale 1ns / 1ps
module swmf_ram #(
    parameter int Depth = 16,
    parameter int Width = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/swmf_sorter.sv @@
`timescale 1ns / 1ps
// Insertion sorter: one value in per cycle while i_push is high into a sorted register row
module swmf_sorter (
    input  logic                    i_clk,
    input  logic                    i_clear,
    input  logic                    i_push,
    input  swmf_pkg::t_sample       i_value,
    input  swmf_pkg::t_cnt          i_size,
    output swmf_pkg::t_sample       o_median
);
    swmf_pkg::t_sample r_row [swmf_pkg::WindowMax];
    swmf_pkg::t_sample n_row [swmf_pkg::WindowMax];
    swmf_pkg::t_cnt    r_fill;
    swmf_pkg::t_addr   lo_idx;
    swmf_pkg::t_addr   hi_idx;
    logic signed [swmf_pkg::SampleW:0] sum;

    // Shift larger entries up and drop the new value in place
    always_comb begin
        for (int k = 0; k < swmf_pkg::WindowMax; k++) begin
            n_row[k] = r_row[k];
            if (32'(r_fill) > k) begin
                if (k > 0 && r_row[k-1] > i_value) begin
                    n_row[k] = r_row[k-1];
                end else if (r_row[k] > i_value) begin
                    n_row[k] = i_value;
                end
            end else if (32'(r_fill) == k) begin
                if (k > 0 && r_row[k-1] > i_value) begin
                    n_row[k] = r_row[k-1];
                end else begin
                    n_row[k] = i_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_fill <= '0;
        end else if (i_push) begin
            r_fill <= r_fill + 1'b1;
            r_row  <= n_row;
        end
    end

    // Pick middle entries; even size averages with floor
    always_comb begin
        hi_idx = swmf_pkg::t_addr'(i_size >> 1);
        lo_idx = i_size[0] ? hi_idx : hi_idx - 1'b1;
        sum    = {r_row[lo_idx][swmf_pkg::SampleW-1], r_row[lo_idx]}
               + {r_row[hi_idx][swmf_pkg::SampleW-1], r_row[hi_idx]};
        o_median = swmf_pkg::t_sample'(sum >>> 1);
    end
endmodule
